/* src/bcsc_pkg.sv */
// Shared definitions for the box collision side classifier.
// Holds the side codes and the default coordinate width; no dependencies.
package bcsc_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int SIDE_W         = 3;

    typedef enum logic [SIDE_W-1:0] {
        SIDE_NONE   = 3'd0,
        SIDE_INSIDE = 3'd1,
        SIDE_RIGHT  = 3'd2,
        SIDE_TOP    = 3'd3,
        SIDE_LEFT   = 3'd4,
        SIDE_BOTTOM = 3'd5
    } side_t;

endpackage

/* src/box_collision_side_classifier_unit.sv */
// Top level of the box collision side classifier: a four-stage pipeline.
// Depends on bcsc_pkg for the side codes and the default coordinate width.
//
//  Channel   Handshake          Payload
//  s_ (in)   s_valid / s_ready  two boxes (center, half extents), second box velocity
//  m_ (out)  m_valid / m_ready  m_side, one result per input transfer
//
// Every transfer passes four register stages: box edges, region decode with corner
// offsets, the two slope cross products, then the final compare.
// The multiplier stage sets the clock; one transfer can enter every cycle unless a
// stall on m_ready has filled every stage.
// Reset (aresetn, synchronous, active low) clears only the stage valid bits.
// A stall on m_ready holds the full stages at the output end; stages behind an empty
// one still move up, so input transfers are taken while a finished result waits.
module box_collision_side_classifier_unit #(
    parameter int COORD_BITS = bcsc_pkg::COORD_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [COORD_BITS-1:0]  s_my_center_x,
    input  logic signed [COORD_BITS-1:0]  s_my_center_y,
    input  logic        [COORD_BITS-2:0]  s_my_half_width,
    input  logic        [COORD_BITS-2:0]  s_my_half_height,
    input  logic signed [COORD_BITS-1:0]  s_other_center_x,
    input  logic signed [COORD_BITS-1:0]  s_other_center_y,
    input  logic        [COORD_BITS-2:0]  s_other_half_width,
    input  logic        [COORD_BITS-2:0]  s_other_half_height,
    input  logic signed [COORD_BITS-1:0]  s_other_vel_x,
    input  logic signed [COORD_BITS-1:0]  s_other_vel_y,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [bcsc_pkg::SIDE_W-1:0]   m_side
);
    import bcsc_pkg::*;

    localparam int C = COORD_BITS;
    localparam int E = COORD_BITS + 1;       // edges and centers
    localparam int D = COORD_BITS + 2;       // corner offsets
    localparam int P = 2 * COORD_BITS + 2;   // cross products

    // Stage valid bits and per-stage load enables.
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic en1, en2, en3, en4;

    assign en4     = !v4_reg || m_ready;
    assign en3     = !v3_reg || en4;
    assign en2     = !v2_reg || en3;
    assign en1     = !v1_reg || en2;
    assign s_ready = en1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (en1) v1_reg <= s_valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
        end
    end

    // ---------------- Stage 1: box edges ----------------
    logic signed [E-1:0] left_reg, right_reg, top_reg, bottom_reg;
    logic signed [E-1:0] oleft_reg, oright_reg, otop_reg, obottom_reg;
    logic signed [E-1:0] ox_reg, oy_reg;
    logic signed [C-1:0] vx1_reg, vy1_reg;

    logic signed [E-1:0] mcx_e, mcy_e, ox_e, oy_e, mw_e, mh_e, ow_e, oh_e;

    assign mcx_e = E'(s_my_center_x);
    assign mcy_e = E'(s_my_center_y);
    assign ox_e  = E'(s_other_center_x);
    assign oy_e  = E'(s_other_center_y);
    assign mw_e  = E'($signed({1'b0, s_my_half_width}));
    assign mh_e  = E'($signed({1'b0, s_my_half_height}));
    assign ow_e  = E'($signed({1'b0, s_other_half_width}));
    assign oh_e  = E'($signed({1'b0, s_other_half_height}));

    always_ff @(posedge aclk) begin
        if (en1) begin
            left_reg    <= mcx_e - mw_e;
            right_reg   <= mcx_e + mw_e;
            top_reg     <= mcy_e + mh_e;
            bottom_reg  <= mcy_e - mh_e;
            oleft_reg   <= ox_e - ow_e;
            oright_reg  <= ox_e + ow_e;
            otop_reg    <= oy_e + oh_e;
            obottom_reg <= oy_e - oh_e;
            ox_reg      <= ox_e;
            oy_reg      <= oy_e;
            vx1_reg     <= s_other_vel_x;
            vy1_reg     <= s_other_vel_y;
        end
    end

    // ---------------- Stage 2: region decode and corner offsets ----------------
    logic  in_x, in_y, on_x, on_y, past_r, past_l, past_t, past_b;
    logic  ovl_r, ovl_l, ovl_t, ovl_b;
    logic  ovl_r_strict, ovl_l_strict, ovl_t_strict, ovl_b_strict;
    side_t fixed_side_next, first_side_next, second_side_next;
    logic  use_slope_next;
    logic signed [E-1:0] corner_x, corner_y;

    assign in_x   = (left_reg < ox_reg) && (ox_reg < right_reg);
    assign in_y   = (bottom_reg < oy_reg) && (oy_reg < top_reg);
    assign on_x   = (left_reg <= ox_reg) && (ox_reg <= right_reg);
    assign on_y   = (bottom_reg <= oy_reg) && (oy_reg <= top_reg);
    assign past_r = right_reg < ox_reg;
    assign past_l = ox_reg < left_reg;
    assign past_t = top_reg < oy_reg;
    assign past_b = oy_reg < bottom_reg;

    assign ovl_r        = oleft_reg <= right_reg;
    assign ovl_l        = left_reg <= oright_reg;
    assign ovl_t        = obottom_reg <= top_reg;
    assign ovl_b        = bottom_reg <= otop_reg;
    assign ovl_r_strict = oleft_reg < right_reg;
    assign ovl_l_strict = left_reg < oright_reg;
    assign ovl_t_strict = obottom_reg < top_reg;
    assign ovl_b_strict = bottom_reg < otop_reg;

    assign corner_x = past_r ? right_reg : left_reg;
    assign corner_y = past_t ? top_reg : bottom_reg;

    always_comb begin
        fixed_side_next  = SIDE_NONE;
        first_side_next  = SIDE_NONE;
        second_side_next = SIDE_NONE;
        use_slope_next   = 1'b0;
        if (in_x && in_y) begin
            fixed_side_next = SIDE_INSIDE;
        end else if (past_r && on_y) begin
            fixed_side_next = ovl_r ? SIDE_RIGHT : SIDE_NONE;
        end else if (past_t && on_x) begin
            fixed_side_next = ovl_t ? SIDE_TOP : SIDE_NONE;
        end else if (past_l && on_y) begin
            fixed_side_next = ovl_l ? SIDE_LEFT : SIDE_NONE;
        end else if (past_b && on_x) begin
            fixed_side_next = ovl_b ? SIDE_BOTTOM : SIDE_NONE;
        end else if (past_r && past_t) begin
            use_slope_next   = ovl_r_strict && ovl_t_strict;
            first_side_next  = SIDE_RIGHT;
            second_side_next = SIDE_TOP;
        end else if (past_l && past_t) begin
            use_slope_next   = ovl_l_strict && ovl_t_strict;
            first_side_next  = SIDE_TOP;
            second_side_next = SIDE_LEFT;
        end else if (past_l && past_b) begin
            use_slope_next   = ovl_l_strict && ovl_b_strict;
            first_side_next  = SIDE_LEFT;
            second_side_next = SIDE_BOTTOM;
        end else if (past_r && past_b) begin
            use_slope_next   = ovl_r_strict && ovl_b_strict;
            first_side_next  = SIDE_BOTTOM;
            second_side_next = SIDE_RIGHT;
        end
    end

    side_t fixed2_reg, first2_reg, second2_reg;
    logic  use_slope2_reg;
    logic signed [D-1:0] dx_reg, dy_reg;
    logic signed [C-1:0] vx2_reg, vy2_reg;

    always_ff @(posedge aclk) begin
        if (en2) begin
            fixed2_reg     <= fixed_side_next;
            first2_reg     <= first_side_next;
            second2_reg    <= second_side_next;
            use_slope2_reg <= use_slope_next;
            dx_reg         <= D'(ox_reg) - D'(corner_x);
            dy_reg         <= D'(oy_reg) - D'(corner_y);
            vx2_reg        <= vx1_reg;
            vy2_reg        <= vy1_reg;
        end
    end

    // ---------------- Stage 3: slope cross products ----------------
    logic signed [P-1:0] lhs_next, rhs_next;
    logic                vy_pos, dy_pos;

    assign lhs_next = P'(vx2_reg) * P'(dy_reg);
    assign rhs_next = P'(dx_reg) * P'(vy2_reg);
    assign vy_pos   = !vy2_reg[C-1] && (vy2_reg != '0);
    assign dy_pos   = !dy_reg[D-1] && (dy_reg != '0);

    side_t fixed3_reg, first3_reg, second3_reg;
    logic  use_slope3_reg, vy_zero3_reg, vx_neg3_reg, same_sign3_reg;
    logic signed [P-1:0] lhs_reg, rhs_reg;

    always_ff @(posedge aclk) begin
        if (en3) begin
            fixed3_reg     <= fixed2_reg;
            first3_reg     <= first2_reg;
            second3_reg    <= second2_reg;
            use_slope3_reg <= use_slope2_reg;
            vy_zero3_reg   <= (vy2_reg == '0);
            vx_neg3_reg    <= vx2_reg[C-1];
            same_sign3_reg <= (vy_pos == dy_pos);
            lhs_reg        <= lhs_next;
            rhs_reg        <= rhs_next;
        end
    end

    // ---------------- Stage 4: slope compare and result register ----------------
    // A zero vertical velocity acts as an infinite slope: only a negative
    // horizontal velocity orders below the corner slope.
    logic  slope_less;
    side_t side_next;
    side_t side_reg;

    always_comb begin
        if (vy_zero3_reg) begin
            slope_less = vx_neg3_reg;
        end else if (same_sign3_reg) begin
            slope_less = lhs_reg < rhs_reg;
        end else begin
            slope_less = lhs_reg > rhs_reg;
        end
        if (use_slope3_reg) begin
            side_next = slope_less ? first3_reg : second3_reg;
        end else begin
            side_next = fixed3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en4) begin
            side_reg <= side_next;
        end
    end

    assign m_valid = v4_reg;
    assign m_side  = side_reg;

endmodule
